@@ sv/tca_pkg.sv @@
// ----------------------------------------------------------------------------
// tca_pkg
// Shared types and constants of the typed constant ALU: operation codes,
// operand tags, status codes and the transaction structs of both channels.
// ----------------------------------------------------------------------------
package tca_pkg;

  typedef enum logic [4:0] {
    MD_ADD  = 5'd0,
    MD_SUB  = 5'd1,
    MD_MUL  = 5'd2,
    MD_DIV  = 5'd3,
    MD_MOD  = 5'd4,
    MD_SHL  = 5'd5,
    MD_SHR  = 5'd6,
    MD_LT   = 5'd7,
    MD_LE   = 5'd8,
    MD_GT   = 5'd9,
    MD_GE   = 5'd10,
    MD_EQ   = 5'd11,
    MD_NE   = 5'd12,
    MD_AND  = 5'd13,
    MD_XOR  = 5'd14,
    MD_OR   = 5'd15,
    MD_LAND = 5'd16,
    MD_LOR  = 5'd17,
    MD_POS  = 5'd18,
    MD_NEG  = 5'd19,
    MD_LNOT = 5'd20,
    MD_BNOT = 5'd21
  } mode_e;

  typedef enum logic [1:0] {
    TAG_I32 = 2'd0,
    TAG_F32 = 2'd1,
    TAG_STR = 2'd2
  } tag_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_BADTYPE  = 2'd2,
    ST_DIVZERO  = 2'd3
  } status_e;

  localparam logic [4:0]  SHIFT_MASK = 5'h1f;
  localparam logic [31:0] ALL_ONES   = 32'hffff_ffff;
  localparam logic [31:0] SIGN_BIT   = 32'h8000_0000;
  localparam logic [31:0] CANON_NAN  = 32'h7fc0_0000;
  localparam int unsigned DIV_STEPS  = 32;

  typedef struct packed {
    logic [4:0]  mode;
    logic [1:0]  left_tag;
    logic [31:0] left_bits;
    logic [1:0]  right_tag;
    logic [31:0] right_bits;
  } in_t;

  typedef struct packed {
    logic        result_tag;
    logic [31:0] result_bits;
    logic [1:0]  status;
  } out_t;

endpackage

@@ sv/typed_constant_alu_top.sv @@
// ----------------------------------------------------------------------------
// typed_constant_alu_top
// Pipelined typed ALU for i32 and IEEE single operands: integer and float
// add, sub, mul, div, integer mod, shifts, compares, bitwise, logical and
// unary operations, with a status for type errors and division by zero.
// ----------------------------------------------------------------------------
//  channel | dir | handshake               | payload
//  in      | in  | in_valid_i / in_ready_o | in_data_i  (in_t)
//  out     | out | out_valid_o/out_ready_i | out_data_o (out_t)
//
//  One transaction per cycle unless the output stalls. Stages: decode,
//  operand normalize, multiply/align, 32 restoring divide steps (one quotient
//  bit each), result form, leading-zero count, normalize shift, round/pack.
//  The divide steps set the depth; every transaction passes through them.
//  Reset clears the stage valid bits only. A stalled output holds the whole
//  pipeline; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module typed_constant_alu_top
  import tca_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  localparam int unsigned S_DIV0   = 3;
  localparam int unsigned S_FORM   = S_DIV0 + DIV_STEPS;
  localparam int unsigned S_LZC    = S_FORM + 1;
  localparam int unsigned S_SHF    = S_LZC + 1;
  localparam int unsigned S_RND    = S_SHF + 1;
  localparam int unsigned NUM_STG  = S_RND + 1;

  typedef enum logic [2:0] {
    K_FIX, K_IMUL, K_IDIV, K_IMOD, K_FADD, K_FMUL, K_FDIV
  } kind_e;

  typedef struct packed {
    logic               fin;
    kind_e              kind;
    status_e            status;
    logic               rtag;
    logic [31:0]        rbits;
    logic [31:0]        a;
    logic [31:0]        b;
    logic               sgn;
    logic               eff_sub;
    logic               neg_res;
    logic               q0;
    logic signed [10:0] ea;
    logic signed [10:0] eb;
    logic [23:0]        ma;
    logic [23:0]        mb;
    logic [4:0]         lza;
    logic [4:0]         lzb;
    logic [49:0]        my;
    logic [47:0]        prod;
    logic [31:0]        xq;
    logic [31:0]        rem;
    logic [31:0]        dvs;
    logic signed [10:0] ex;
    logic [49:0]        mw;
    logic [5:0]         shl;
    logic [5:0]         shr;
    logic [7:0]         ef;
    logic               ovf;
    logic               stk;
  } ctx_t;

  function automatic logic [4:0] lzc24(logic [23:0] v);
    logic [4:0] n;
    n = 5'd24;
    for (int i = 0; i < 24; i++) begin
      if (v[i]) n = 5'(23 - i);
    end
    return n;
  endfunction

  function automatic logic [5:0] lzc50(logic [49:0] v);
    logic [5:0] n;
    n = 6'd50;
    for (int i = 0; i < 50; i++) begin
      if (v[i]) n = 6'(49 - i);
    end
    return n;
  endfunction

  function automatic ctx_t st_decode(in_t d);
    ctx_t        c;
    logic [31:0] a, b, ka, kb;
    logic [4:0]  sh;
    logic [7:0]  xa, xb;
    logic        na, nb, ia, ib, za, zb, bz, un, ltf, gtf, eqf, sy;
    a  = d.left_bits;
    b  = d.right_bits;
    sh = b[4:0] & SHIFT_MASK;
    c  = '0;
    c.fin    = 1'b1;
    c.kind   = K_FIX;
    c.status = ST_OK;
    c.a      = a;
    c.b      = b;
    xa = a[30:23];
    xb = b[30:23];
    na = (&xa) & (|a[22:0]);
    nb = (&xb) & (|b[22:0]);
    ia = (&xa) & ~(|a[22:0]);
    ib = (&xb) & ~(|b[22:0]);
    za = ~(|a[30:0]);
    zb = ~(|b[30:0]);
    bz = za & zb;
    un = na | nb;
    ka = a[31] ? ~a : (a ^ SIGN_BIT);
    kb = b[31] ? ~b : (b ^ SIGN_BIT);
    eqf = ~un & ((a == b) | bz);
    ltf = ~un & ~bz & (ka < kb);
    gtf = ~un & ~bz & (kb < ka);
    sy  = b[31] ^ (d.mode == MD_SUB);
    c.ma  = {|xa, a[22:0]};
    c.mb  = {|xb, b[22:0]};
    c.ea  = (xa == 8'd0) ? 11'sd1 : $signed({3'b0, xa});
    c.eb  = (xb == 8'd0) ? 11'sd1 : $signed({3'b0, xb});
    c.lza = lzc24(c.ma);
    c.lzb = lzc24(c.mb);
    c.sgn = a[31] ^ b[31];
    if (d.mode > MD_BNOT) begin
      c.status = ST_BADTYPE;
    end else if (d.mode >= MD_POS) begin
      if (d.left_tag == TAG_I32) begin
        unique case (mode_e'(d.mode))
          MD_POS:  c.rbits = a;
          MD_NEG:  c.rbits = 32'd0 - a;
          MD_LNOT: c.rbits = {31'd0, a == 32'd0};
          default: c.rbits = ALL_ONES ^ a;
        endcase
      end else if (d.left_tag == TAG_F32 && d.mode == MD_POS) begin
        c.rtag  = 1'b1;
        c.rbits = a;
      end else if (d.left_tag == TAG_F32 && d.mode == MD_NEG) begin
        c.rtag  = 1'b1;
        c.rbits = a ^ SIGN_BIT;
      end else begin
        c.status = ST_BADTYPE;
      end
    end else if (d.left_tag != d.right_tag) begin
      c.status = ST_MISMATCH;
    end else if (d.left_tag == TAG_I32) begin
      unique case (mode_e'(d.mode))
        MD_ADD:  c.rbits = a + b;
        MD_SUB:  c.rbits = a - b;
        MD_MUL: begin
          c.fin  = 1'b0;
          c.kind = K_IMUL;
        end
        MD_DIV, MD_MOD: begin
          if (b == 32'd0) begin
            c.status = ST_DIVZERO;
          end else begin
            c.fin     = 1'b0;
            c.kind    = (d.mode == MD_DIV) ? K_IDIV : K_IMOD;
            c.xq      = a[31] ? (32'd0 - a) : a;
            c.dvs     = b[31] ? (32'd0 - b) : b;
            c.neg_res = (d.mode == MD_DIV) ? (a[31] ^ b[31]) : a[31];
          end
        end
        MD_SHL:  c.rbits = a << sh;
        MD_SHR:  c.rbits = $unsigned($signed(a) >>> sh);
        MD_LT:   c.rbits = {31'd0, $signed(a) < $signed(b)};
        MD_LE:   c.rbits = {31'd0, $signed(a) <= $signed(b)};
        MD_GT:   c.rbits = {31'd0, $signed(a) > $signed(b)};
        MD_GE:   c.rbits = {31'd0, $signed(a) >= $signed(b)};
        MD_EQ:   c.rbits = {31'd0, a == b};
        MD_NE:   c.rbits = {31'd0, a != b};
        MD_AND:  c.rbits = a & b;
        MD_XOR:  c.rbits = a ^ b;
        MD_OR:   c.rbits = a | b;
        MD_LAND: c.rbits = {31'd0, (a != 32'd0) && (b != 32'd0)};
        MD_LOR:  c.rbits = {31'd0, (a != 32'd0) || (b != 32'd0)};
        default: c.status = ST_BADTYPE;
      endcase
    end else if (d.left_tag == TAG_F32) begin
      unique case (mode_e'(d.mode))
        MD_ADD, MD_SUB: begin
          c.rtag = 1'b1;
          if (un | (ia & ib & (a[31] != sy))) begin
            c.rbits = CANON_NAN;
          end else if (ia) begin
            c.rbits = a;
          end else if (ib) begin
            c.rbits = {sy, b[30:0]};
          end else begin
            c.fin     = 1'b0;
            c.kind    = K_FADD;
            c.eff_sub = a[31] ^ sy;
            if (b[30:0] > a[30:0]) begin
              c.sgn = sy;
              c.ma  = {|xb, b[22:0]};
              c.mb  = {|xa, a[22:0]};
              c.ea  = (xb == 8'd0) ? 11'sd1 : $signed({3'b0, xb});
              c.eb  = (xa == 8'd0) ? 11'sd1 : $signed({3'b0, xa});
            end else begin
              c.sgn = a[31];
            end
          end
        end
        MD_MUL: begin
          c.rtag = 1'b1;
          if (un | (ia & zb) | (za & ib)) begin
            c.rbits = CANON_NAN;
          end else if (ia | ib) begin
            c.rbits = {c.sgn, 8'hff, 23'd0};
          end else if (za | zb) begin
            c.rbits = {c.sgn, 31'd0};
          end else begin
            c.fin  = 1'b0;
            c.kind = K_FMUL;
          end
        end
        MD_DIV: begin
          c.rtag = 1'b1;
          if (zb) begin
            c.status = ST_DIVZERO;
          end else if (un | (ia & ib)) begin
            c.rbits = CANON_NAN;
          end else if (ia) begin
            c.rbits = {c.sgn, 8'hff, 23'd0};
          end else if (ib | za) begin
            c.rbits = {c.sgn, 31'd0};
          end else begin
            c.fin  = 1'b0;
            c.kind = K_FDIV;
          end
        end
        MD_LT:   c.rbits = {31'd0, ltf};
        MD_LE:   c.rbits = {31'd0, ltf | eqf};
        MD_GT:   c.rbits = {31'd0, gtf};
        MD_GE:   c.rbits = {31'd0, gtf | eqf};
        MD_EQ:   c.rbits = {31'd0, eqf};
        MD_NE:   c.rbits = {31'd0, ~eqf};
        default: c.status = ST_BADTYPE;
      endcase
    end else begin
      c.status = ST_BADTYPE;
    end
    return c;
  endfunction

  function automatic ctx_t st_prep(ctx_t ci);
    ctx_t               c;
    logic [23:0]        ma, mb;
    logic signed [10:0] d;
    logic [99:0]        al;
    c  = ci;
    ma = ci.ma << ci.lza;
    mb = ci.mb << ci.lzb;
    d  = ci.ea - ci.eb;
    if (ci.kind == K_FMUL || ci.kind == K_FDIV) begin
      c.ma = ma;
      c.mb = mb;
      c.ea = ci.ea - $signed({6'd0, ci.lza});
      c.eb = ci.eb - $signed({6'd0, ci.lzb});
      if (ci.kind == K_FMUL) begin
        c.ex = c.ea + c.eb - 11'sd126;
      end else begin
        c.ex  = c.ea - c.eb + 11'sd127;
        c.q0  = (ma >= mb);
        c.rem = {8'd0, ma - (c.q0 ? mb : 24'd0)};
        c.xq  = 32'd0;
        c.dvs = {8'd0, mb};
      end
    end else if (ci.kind == K_FADD) begin
      c.ex = ci.ea + 11'sd1;
      if (d > 11'sd49) begin
        c.my = {49'd0, |ci.mb};
      end else begin
        al   = {1'b0, ci.mb, 25'd0, 50'd0} >> d[5:0];
        c.my = al[99:50] | {49'd0, |al[49:0]};
      end
    end
    return c;
  endfunction

  function automatic ctx_t st_mult(ctx_t ci);
    ctx_t        c;
    logic [49:0] mx;
    c  = ci;
    mx = {1'b0, ci.ma, 25'd0};
    c.prod = ci.ma * ci.mb;
    if (ci.kind == K_IMUL) begin
      c.rbits = ci.a * ci.b;
      c.fin   = 1'b1;
    end
    if (ci.kind == K_FADD) begin
      c.mw = ci.eff_sub ? (mx - ci.my) : (mx + ci.my);
    end
    return c;
  endfunction

  function automatic ctx_t st_div(ctx_t ci);
    ctx_t        c;
    logic [32:0] t;
    logic        qb;
    c  = ci;
    t  = {ci.rem, ci.xq[31]};
    qb = (t >= {1'b0, ci.dvs});
    if (qb) t = t - {1'b0, ci.dvs};
    c.rem = t[31:0];
    c.xq  = {ci.xq[30:0], qb};
    return c;
  endfunction

  function automatic ctx_t st_form(ctx_t ci);
    ctx_t c;
    c = ci;
    case (ci.kind)
      K_IDIV: begin
        c.rbits = ci.neg_res ? (32'd0 - ci.xq) : ci.xq;
        c.fin   = 1'b1;
      end
      K_IMOD: begin
        c.rbits = ci.neg_res ? (32'd0 - ci.rem) : ci.rem;
        c.fin   = 1'b1;
      end
      K_FMUL:  c.mw = {ci.prod, 2'b00};
      K_FDIV:  c.mw = {ci.q0, ci.xq, 17'd0} | {49'd0, |ci.rem};
      default: c.mw = ci.mw;
    endcase
    return c;
  endfunction

  function automatic ctx_t st_lzc(ctx_t ci);
    ctx_t               c;
    logic [5:0]         lz;
    logic signed [10:0] diff, t;
    c    = ci;
    lz   = lzc50(ci.mw);
    diff = ci.ex - $signed({5'd0, lz});
    t    = 11'sd1 - ci.ex;
    c.shl = 6'd0;
    c.shr = 6'd0;
    c.ef  = 8'd0;
    c.ovf = 1'b0;
    if (!ci.fin) begin
      if (ci.mw == 50'd0) begin
        c.fin   = 1'b1;
        c.rtag  = 1'b1;
        c.rbits = {ci.sgn & ~ci.eff_sub, 31'd0};
      end else if (diff >= 11'sd1) begin
        c.shl = lz;
        c.ovf = (diff > 11'sd254);
        c.ef  = diff[7:0];
      end else if (ci.ex >= 11'sd1) begin
        c.shl = 6'(ci.ex - 11'sd1);
      end else begin
        c.shr = (t > 11'sd63) ? 6'd63 : 6'(t);
      end
    end
    return c;
  endfunction

  function automatic ctx_t st_shift(ctx_t ci);
    ctx_t        c;
    logic [99:0] sr;
    c  = ci;
    sr = {ci.mw, 50'd0} >> ci.shr;
    if (ci.shr != 6'd0) begin
      c.mw  = sr[99:50];
      c.stk = |sr[49:0];
    end else begin
      c.mw  = ci.mw << ci.shl;
      c.stk = 1'b0;
    end
    return c;
  endfunction

  function automatic ctx_t st_round(ctx_t ci);
    ctx_t        c;
    logic        inc;
    logic [30:0] mag;
    c   = ci;
    inc = ci.mw[25] & ((|ci.mw[24:0]) | ci.stk | ci.mw[26]);
    mag = {ci.ef, ci.mw[48:26]} + {30'd0, inc};
    if (!ci.fin) begin
      c.fin   = 1'b1;
      c.rtag  = 1'b1;
      c.rbits = ci.ovf ? {ci.sgn, 8'hff, 23'd0} : {ci.sgn, mag};
    end
    return c;
  endfunction

  ctx_t               stg_d [NUM_STG];
  ctx_t               stg_q [NUM_STG];
  logic [NUM_STG-1:0] vld_d, vld_q;
  logic               adv;

  assign adv         = ~vld_q[NUM_STG-1] | out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = vld_q[NUM_STG-1];
  assign vld_d       = {vld_q[NUM_STG-2:0], in_valid_i};

  always_comb begin
    stg_d[0] = st_decode(in_data_i);
    stg_d[1] = st_prep(stg_q[0]);
    stg_d[2] = st_mult(stg_q[1]);
    for (int i = 0; i < DIV_STEPS; i++) begin
      stg_d[S_DIV0 + i] = st_div(stg_q[S_DIV0 + i - 1]);
    end
    stg_d[S_FORM] = st_form(stg_q[S_FORM - 1]);
    stg_d[S_LZC]  = st_lzc(stg_q[S_LZC - 1]);
    stg_d[S_SHF]  = st_shift(stg_q[S_SHF - 1]);
    stg_d[S_RND]  = st_round(stg_q[S_RND - 1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      stg_q <= stg_d;
    end
  end

  always_comb begin
    out_data_o.status      = stg_q[S_RND].status;
    out_data_o.result_tag  = (stg_q[S_RND].status == ST_OK) ? stg_q[S_RND].rtag : 1'b0;
    out_data_o.result_bits = (stg_q[S_RND].status == ST_OK) ? stg_q[S_RND].rbits : 32'd0;
  end

endmodule

@@ verif/tca_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tca_checker
// Watches both channels of the typed constant ALU, computes the expected
// result of every accepted input transaction (integer arithmetic on bit
// vectors, single precision float through real with round to nearest even)
// and compares each output transaction with the oldest expected result.
// ----------------------------------------------------------------------------
module tca_checker
  import tca_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  in_t  in_data_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  out_t out_data_i,
  output int   fail_count_o,
  output int   pending_o
);

  out_t alu_results_q[$];
  int   fail_count;

  function automatic real single_to_real(logic [31:0] v);
    logic [63:0] d;
    real         r;
    if (v[30:23] == 8'd0) begin
      r = real'(v[22:0]) * (2.0 ** -149);
      return v[31] ? -r : r;
    end
    if (v[30:23] == 8'hff) d = {v[31], 11'h7ff, v[22:0], 29'd0};
    else d = {v[31], 3'd0, v[30:23], v[22:0], 29'd0} + {1'b0, 11'd896, 52'd0};
    return $bitstoreal(d);
  endfunction

  function automatic logic [31:0] real_to_single(real r);
    logic [63:0] d;
    logic [63:0] mant;
    logic [63:0] kept;
    logic [63:0] rest;
    logic [63:0] half;
    int          e;
    int          sh;
    d = $realtobits(r);
    if (d[62:52] == 11'h7ff) return (d[51:0] != 0) ? CANON_NAN : {d[63], 8'hff, 23'd0};
    if (d[62:52] == 11'd0) return {d[63], 31'd0};
    e = int'(d[62:52]) - 1023;
    if (e > 127) return {d[63], 8'hff, 23'd0};
    mant = {11'd0, 1'b1, d[51:0]};
    sh = (e >= -126) ? 29 : 29 + (-126 - e);
    if (sh >= 60) return {d[63], 31'd0};
    kept = mant >> sh;
    rest = mant & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    if (rest > half || (rest == half && kept[0])) kept = kept + 1;
    if (e < -126) return {d[63], kept[30:0]};
    if (kept[24]) begin
      kept = kept >> 1;
      e = e + 1;
    end
    if (e > 127) return {d[63], 8'hff, 23'd0};
    return {d[63], 8'(e + 127), kept[22:0]};
  endfunction

  function automatic out_t alu_predict(in_t t);
    out_t        o;
    logic [31:0] a;
    logic [31:0] b;
    logic [4:0]  s;
    longint      sa;
    longint      sb;
    real         x;
    real         y;
    a = t.left_bits;
    b = t.right_bits;
    s = b[4:0] & SHIFT_MASK;
    o = '0;
    o.status = ST_OK;
    o.result_tag = 1'b0;
    if (t.mode > MD_BNOT) begin
      o.status = ST_BADTYPE;
    end else if (t.mode >= MD_POS) begin
      if (t.left_tag == TAG_I32) begin
        case (t.mode)
          MD_POS:  o.result_bits = a;
          MD_NEG:  o.result_bits = 32'd0 - a;
          MD_LNOT: o.result_bits = (a == 0) ? 32'd1 : 32'd0;
          default: o.result_bits = ALL_ONES ^ a;
        endcase
      end else if (t.left_tag == TAG_F32 && t.mode == MD_POS) begin
        o.result_tag = 1'b1;
        o.result_bits = a;
      end else if (t.left_tag == TAG_F32 && t.mode == MD_NEG) begin
        o.result_tag = 1'b1;
        o.result_bits = a ^ SIGN_BIT;
      end else begin
        o.status = ST_BADTYPE;
      end
    end else if (t.left_tag != t.right_tag) begin
      o.status = ST_MISMATCH;
    end else if (t.left_tag == TAG_I32) begin
      sa = longint'($signed(a));
      sb = longint'($signed(b));
      case (t.mode)
        MD_ADD: o.result_bits = a + b;
        MD_SUB: o.result_bits = a - b;
        MD_MUL: o.result_bits = a * b;
        MD_DIV, MD_MOD: begin
          if (b == 0) o.status = ST_DIVZERO;
          else o.result_bits = (t.mode == MD_DIV) ? 32'(sa / sb) : 32'(sa % sb);
        end
        MD_SHL:  o.result_bits = a << s;
        MD_SHR:  o.result_bits = $unsigned($signed(a) >>> s);
        MD_LT:   o.result_bits = {31'd0, sa < sb};
        MD_LE:   o.result_bits = {31'd0, sa <= sb};
        MD_GT:   o.result_bits = {31'd0, sa > sb};
        MD_GE:   o.result_bits = {31'd0, sa >= sb};
        MD_EQ:   o.result_bits = {31'd0, a == b};
        MD_NE:   o.result_bits = {31'd0, a != b};
        MD_AND:  o.result_bits = a & b;
        MD_XOR:  o.result_bits = a ^ b;
        MD_OR:   o.result_bits = a | b;
        MD_LAND: o.result_bits = {31'd0, a != 0 && b != 0};
        default: o.result_bits = {31'd0, a != 0 || b != 0};
      endcase
    end else if (t.left_tag == TAG_F32) begin
      x = single_to_real(a);
      y = single_to_real(b);
      case (t.mode)
        MD_ADD, MD_SUB, MD_MUL, MD_DIV: begin
          o.result_tag = 1'b1;
          if (t.mode == MD_ADD) o.result_bits = real_to_single(x + y);
          else if (t.mode == MD_SUB) o.result_bits = real_to_single(x - y);
          else if (t.mode == MD_MUL) o.result_bits = real_to_single(x * y);
          else if ((b & ~SIGN_BIT) == 0) o.status = ST_DIVZERO;
          else o.result_bits = real_to_single(x / y);
        end
        MD_LT:   o.result_bits = {31'd0, x < y};
        MD_LE:   o.result_bits = {31'd0, x <= y};
        MD_GT:   o.result_bits = {31'd0, x > y};
        MD_GE:   o.result_bits = {31'd0, x >= y};
        MD_EQ:   o.result_bits = {31'd0, x == y};
        MD_NE:   o.result_bits = {31'd0, x != y};
        default: o.status = ST_BADTYPE;
      endcase
    end else begin
      o.status = ST_BADTYPE;
    end
    if (o.status != ST_OK) begin
      o.result_tag = 1'b0;
      o.result_bits = '0;
    end
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      alu_results_q.delete();
      fail_count = 0;
    end else begin
      if (in_valid_i && in_ready_i) alu_results_q.push_back(alu_predict(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (alu_results_q.size() == 0) begin
          $error("unexpected output transaction %h", out_data_i);
          fail_count++;
        end else begin
          want = alu_results_q.pop_front();
          if (want.result_tag !== out_data_i.result_tag) begin
            $error("result_tag: expected %0d, actual %0d", want.result_tag,
                   out_data_i.result_tag);
            fail_count++;
          end
          if (want.result_bits !== out_data_i.result_bits) begin
            $error("result_bits: expected %h, actual %h", want.result_bits,
                   out_data_i.result_bits);
            fail_count++;
          end
          if (want.status !== out_data_i.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_data_i.status);
            fail_count++;
          end
        end
      end
    end
  end

  assign fail_count_o = fail_count;
  assign pending_o    = alu_results_q.size();

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives directed corner cases and random typed operations into the ALU
// with random idle bursts on both channels, then gives the verdict from
// the checker's failure count.
// ----------------------------------------------------------------------------
module testbench;
  import tca_pkg::*;

  localparam int RANDOM_ITEMS = 1750;
  localparam int QUIET_ITEMS  = 200;
  localparam int CYCLE_LIMIT  = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  bit   quiet = 1'b0;
  int   ready_hold = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  typed_constant_alu_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  tca_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (ready_hold == 0) begin
      ready_hold <= $urandom_range(1, 17);
      out_ready  <= quiet ? 1'b1 : ($urandom_range(0, 2) != 0);
    end else begin
      ready_hold <= ready_hold - 1;
    end
  end

  function automatic logic [31:0] pick_int();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'd1;
      2: return ALL_ONES;
      3: return SIGN_BIT;
      4: return ~SIGN_BIT;
      5: return 32'($urandom_range(0, 40));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_float();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 11))
      0: return {v[31], 31'd0};
      1: return {v[31], 8'hff, 23'd0};
      2: return {v[31], 8'hff, v[22:0] | 23'd1};
      3: return {v[31], 8'd0, v[22:0]};
      4: return {v[31], 8'hfe, v[22:0]};
      5: return {v[31], 8'd127, v[22:0]};
      6: return {v[31], 8'(v[30:23] % 8 + 120), v[22:0]};
      default: return v;
    endcase
  endfunction

  task automatic send(in_t t);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic send_op(mode_e m, tag_e lt, logic [31:0] a, tag_e rt, logic [31:0] b);
    in_t t;
    t.mode = m;
    t.left_tag = lt;
    t.left_bits = a;
    t.right_tag = rt;
    t.right_bits = b;
    send(t);
  endtask

  initial begin
    in_t t;
    logic [1:0] tg;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_op(MD_ADD, TAG_I32, ~SIGN_BIT, TAG_I32, 32'd1);
    send_op(MD_SUB, TAG_I32, SIGN_BIT, TAG_I32, 32'd1);
    send_op(MD_MUL, TAG_I32, ALL_ONES, TAG_I32, ALL_ONES);
    send_op(MD_DIV, TAG_I32, SIGN_BIT, TAG_I32, ALL_ONES);
    send_op(MD_MOD, TAG_I32, SIGN_BIT, TAG_I32, ALL_ONES);
    send_op(MD_MOD, TAG_I32, 32'hffff_fff9, TAG_I32, 32'd2);
    send_op(MD_DIV, TAG_I32, 32'd7, TAG_I32, 32'd0);
    send_op(MD_SHL, TAG_I32, 32'd3, TAG_I32, 32'd33);
    send_op(MD_SHR, TAG_I32, SIGN_BIT, TAG_I32, 32'd31);
    send_op(MD_LT, TAG_I32, SIGN_BIT, TAG_I32, 32'd0);
    send_op(MD_LAND, TAG_I32, 32'd5, TAG_I32, 32'd0);
    send_op(MD_LOR, TAG_I32, 32'd0, TAG_I32, 32'd0);
    send_op(MD_BNOT, TAG_I32, 32'd0, TAG_STR, ALL_ONES);
    send_op(MD_NEG, TAG_I32, SIGN_BIT, TAG_I32, 32'd0);
    send_op(MD_ADD, TAG_F32, 32'h7f80_0000, TAG_F32, 32'hff80_0000);
    send_op(MD_DIV, TAG_F32, 32'h3f80_0000, TAG_F32, SIGN_BIT);
    send_op(MD_MUL, TAG_F32, 32'h7f7f_ffff, TAG_F32, 32'h4000_0000);
    send_op(MD_MUL, TAG_F32, 32'h0000_0001, TAG_F32, 32'h3f00_0000);
    send_op(MD_MOD, TAG_F32, 32'h3f80_0000, TAG_F32, 32'h3f80_0000);
    send_op(MD_NEG, TAG_F32, 32'h7fc0_0001, TAG_I32, 32'd0);
    send_op(MD_LT, TAG_F32, 32'h7fc0_0000, TAG_F32, 32'h3f80_0000);
    send_op(MD_EQ, TAG_F32, SIGN_BIT, TAG_F32, 32'd0);
    send_op(MD_ADD, TAG_STR, 32'd1, TAG_STR, 32'd1);
    send_op(MD_POS, tag_e'(2'd3), 32'd1, TAG_I32, 32'd1);
    send_op(MD_ADD, TAG_I32, 32'd1, TAG_F32, 32'd1);
    t = '0;
    t.mode = 5'd31;
    send(t);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      t.mode = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(22, 31))
                                            : 5'($urandom_range(0, 21));
      case ($urandom_range(0, 9))
        0: tg = 2'($urandom_range(2, 3));
        1, 2, 3, 4: tg = TAG_F32;
        default: tg = TAG_I32;
      endcase
      t.left_tag  = tg;
      t.right_tag = ($urandom_range(0, 9) == 0) ? 2'($urandom) : tg;
      t.left_bits  = (tg == TAG_F32) ? pick_float() : pick_int();
      t.right_bits = (t.right_tag == TAG_F32) ? pick_float() : pick_int();
      send(t);
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ typed_constant_alu_top.f @@
sv/tca_pkg.sv
sv/typed_constant_alu_top.sv
verif/tca_checker.sv
verif/testbench.sv
